@@ rtl/linear_interp_resampler_top_assert.svh @@
// Assertion macros used by the resampler controller.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lir_pkg.sv @@
// Package for the linear interpolation resampler: constants and control structs.
`default_nettype none

package lir_pkg;

    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int STEP_BITS         = 21;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic put_interp;
        logic put_tail;
        logic put_marker;
        logic set_last;
        logic wrap;
        logic finish;
    } lir_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_prev;
        logic pos_lt_one;
        logic interp_last;
        logic tail_last;
        logic end_flag;
        logic out_free;
    } lir_sts_t;

endpackage

`default_nettype wire

@@ rtl/lir_if.sv @@
// Request channel interfaces for the resampler input and output.
`default_nettype none

interface lir_in_if
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          block_end;

    modport source (output valid, output in_sample, output block_end, input ready);
    modport sink   (input valid, input in_sample, input block_end, output ready);
endinterface

interface lir_out_if
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          sample_valid;
    logic                          run_last;

    modport source (output valid, output out_sample, output sample_valid,
                    output run_last, input ready);
    modport sink   (input valid, input out_sample, input sample_valid,
                    input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/lir_datapath.sv @@
// Resampler datapath: phase accumulator, interpolation multiplier and output register.
`default_nettype none

module lir_datapath
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [STEP_BITS-1:0]          cfg_wdata,
    input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
    input  wire logic                          block_end,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic signed [SAMPLE_BITS-1:0] out_sample,
    output      logic                          sample_valid,
    output      logic                          run_last,
    input  wire lir_cmd_t                      cmd,
    output      lir_sts_t                      sts
);

    localparam int POS_BITS  = ((FRACTION_BITS > STEP_BITS) ? FRACTION_BITS : STEP_BITS) + 2;
    localparam int PROD_BITS = SAMPLE_BITS + FRACTION_BITS + 2;
    localparam logic [POS_BITS-1:0]  ONE_POS  = POS_BITS'(1) << FRACTION_BITS;
    localparam logic [POS_BITS-1:0]  TWO_POS  = POS_BITS'(1) << (FRACTION_BITS + 1);
    localparam logic [STEP_BITS-1:0] STEP_RST = STEP_BITS'(ONE_POS);
    localparam logic [STEP_BITS-1:0] STEP_MIN = STEP_BITS'(ONE_POS >> 4);
    localparam logic signed [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRACTION_BITS - 1);

    logic [STEP_BITS-1:0]          step_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic [POS_BITS-1:0]           pos_reg;
    logic [POS_BITS-1:0]           pos_next;
    logic                          have_reg;
    logic                          end_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          sample_valid_reg;
    logic                          run_last_reg;

    logic [STEP_BITS-1:0]          step_eff;
    logic [POS_BITS-1:0]           pos_stepped;
    logic signed [PROD_BITS-1:0]   rnd_sum;
    logic signed [PROD_BITS-1:0]   rnd_shift;
    logic signed [SAMPLE_BITS:0]   interp_val;
    logic                          out_free;
    logic                          put_any;

    // Steps below one sixteenth of a sample are raised to that bound.
    assign step_eff    = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;
    assign pos_stepped = pos_reg + POS_BITS'(step_eff);

    // x[n-1] + round((x[n] - x[n-1]) * f), ties toward plus infinity.
    assign rnd_sum    = prod_reg + HALF;
    assign rnd_shift  = rnd_sum >>> FRACTION_BITS;
    assign interp_val = {prev_reg[SAMPLE_BITS-1], prev_reg} + rnd_shift[SAMPLE_BITS:0];

    assign out_free = !out_valid_reg || out_ready;
    assign put_any  = cmd.put_interp || cmd.put_tail || cmd.put_marker;

    assign sts.have_prev   = have_reg;
    assign sts.pos_lt_one  = pos_reg < ONE_POS;
    assign sts.interp_last = end_reg && (pos_stepped >= TWO_POS);
    assign sts.tail_last   = pos_stepped >= ONE_POS;
    assign sts.end_flag    = end_reg;
    assign sts.out_free    = out_free;

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign sample_valid = sample_valid_reg;
    assign run_last     = run_last_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.put_interp || cmd.put_tail)
        begin
            pos_next = pos_stepped;
        end
        else if (cmd.wrap && have_reg)
        begin
            pos_next = pos_reg - ONE_POS;
        end
        else if (cmd.finish)
        begin
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RST;
            pos_reg       <= '0;
            have_reg      <= 1'b0;
            prev_reg      <= '0;
            end_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            pos_reg <= pos_next;
            if (cmd.load_in)
            begin
                end_reg <= block_end;
            end
            if (cmd.finish)
            begin
                have_reg <= 1'b0;
                prev_reg <= '0;
            end
            else if (cmd.wrap)
            begin
                have_reg <= 1'b1;
                prev_reg <= cur_reg;
            end
            if (put_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_reg  <= in_sample;
            diff_reg <= {in_sample[SAMPLE_BITS-1], in_sample}
                      - {prev_reg[SAMPLE_BITS-1], prev_reg};
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_BITS'(diff_reg * $signed({1'b0, pos_reg[FRACTION_BITS-1:0]}));
        end
        if (cmd.put_interp)
        begin
            out_sample_reg   <= interp_val[SAMPLE_BITS-1:0];
            sample_valid_reg <= 1'b1;
            run_last_reg     <= cmd.set_last;
        end
        else if (cmd.put_tail)
        begin
            out_sample_reg   <= cur_reg;
            sample_valid_reg <= 1'b1;
            run_last_reg     <= cmd.set_last;
        end
        else if (cmd.put_marker)
        begin
            out_sample_reg   <= '0;
            sample_valid_reg <= 1'b0;
            run_last_reg     <= 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lir_ctrl.sv @@
// Resampler controller: sequences interpolated, tail and end-marker outputs per request.
`default_nettype none

`include "linear_interp_resampler_top_assert.svh"

module lir_ctrl
    import lir_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output      logic     in_ready,
    input  wire lir_sts_t sts,
    output      lir_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUT,
        ST_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   emitted_reg;
    logic   emitted_next;

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        emitted_next  = emitted_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load_in   = 1'b1;
                    emitted_next  = 1'b0;
                    in_ready_next = 1'b0;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.have_prev && sts.pos_lt_one)
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_PUT;
                end
                else
                begin
                    cmd.wrap = 1'b1;
                    if (sts.end_flag)
                    begin
                        state_next = ST_TAIL;
                    end
                    else
                    begin
                        in_ready_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            ST_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.put_interp = 1'b1;
                    cmd.set_last   = sts.interp_last;
                    emitted_next   = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            ST_TAIL:
            begin
                // Positions up to one sample past the last sample copy it.
                if (sts.pos_lt_one)
                begin
                    if (sts.out_free)
                    begin
                        cmd.put_tail = 1'b1;
                        cmd.set_last = sts.tail_last;
                        emitted_next = 1'b1;
                    end
                end
                else if (emitted_reg)
                begin
                    cmd.finish    = 1'b1;
                    in_ready_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    // The block-end request gave no sample, so a bare end marker goes out.
                    cmd.put_marker = 1'b1;
                    cmd.finish     = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
            emitted_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
            emitted_reg  <= emitted_next;
        end
    end

    `LIR_ASSERT_NOW(a_put_needs_room,
                    (cmd.put_interp || cmd.put_tail || cmd.put_marker), sts.out_free,
                    "output loaded while the output register is still occupied")
    `LIR_ASSERT_NOW(a_one_put, 1'b1,
                    $onehot0({cmd.put_interp, cmd.put_tail, cmd.put_marker}),
                    "more than one output load in a cycle")
    `LIR_ASSERT_NOW(a_interp_in_range, cmd.put_interp, (sts.have_prev && sts.pos_lt_one),
                    "interpolation outside the current sample interval")
    `LIR_ASSERT_NOW(a_finish_on_end, cmd.finish, sts.end_flag,
                    "block closed without an end-of-block request")
    `LIR_ASSERT_NEXT(a_busy_after_accept, (in_valid && in_ready), !in_ready,
                     "input taken again before the current request was worked off")

endmodule

`default_nettype wire

@@ rtl/linear_interp_resampler_top.sv @@
// Top level of the linear interpolation resampler, one mono channel.
//
// Channels: sample_in carries one signed sample and a block_end flag per
// request; sample_out carries out_sample, sample_valid and run_last. Both use
// valid/ready and move a request at a clock edge where both are high.
// cfg_we with cfg_wdata writes phase_step, the output spacing in Q16 input
// samples; write it only while the block is idle.
// Each input request goes through a check of the phase; each interpolated
// output then takes a multiply into the product register and a load of
// the output register, and after a block-end request the tail outputs copy
// the last sample. The single multiplier and its product register set the
// pace of interpolated outputs, and the sequencer waits while the output
// register is occupied. The input is ready again once the sequencer has
// worked off the current request and returned to idle.
// Reset clears the phase and the held sample, empties the output register
// and sets phase_step to one sample. When the receiver stalls, the output
// register holds its result and the sequencer waits; no result is lost.
`default_nettype none

module linear_interp_resampler_top
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [STEP_BITS-1:0] cfg_wdata,
    lir_in_if.sink                    sample_in,
    lir_out_if.source                 sample_out
);

    lir_cmd_t cmd;
    lir_sts_t sts;
    logic     in_ready;

    assign sample_in.ready = in_ready;

    lir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lir_datapath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_sample    (sample_in.in_sample),
        .block_end    (sample_in.block_end),
        .out_valid    (sample_out.valid),
        .out_ready    (sample_out.ready),
        .out_sample   (sample_out.out_sample),
        .sample_valid (sample_out.sample_valid),
        .run_last     (sample_out.run_last),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the linear interpolation resampler top level.
`default_nettype none

module tb
    import lir_pkg::*;
();

    localparam int SB = SAMPLE_BITS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam logic [STEP_BITS:0]   ONE_POS    = (STEP_BITS + 1)'(1 << FB);
    localparam logic [STEP_BITS-1:0] STEP_FLOOR = STEP_BITS'(1 << (FB - 4));
    localparam logic [STEP_BITS-1:0] STEP_UNITY = STEP_BITS'(1 << FB);
    localparam logic [STEP_BITS-1:0] STEP_MAX   = '1;
    localparam int SETTLE_CYCLES = 64;
    localparam int STALL_LIMIT   = 1000;

    typedef logic signed [SB-1:0] sample_t;

    localparam sample_t SMP_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam sample_t SMP_MIN = {1'b1, {(SB-1){1'b0}}};

    typedef struct packed {
        sample_t smp;
        logic    vld;
        logic    last;
    } out_rec_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [STEP_BITS-1:0] cfg_wdata;

    lir_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    lir_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    linear_interp_resampler_top #(
        .SAMPLE_BITS   (SB),
        .FRACTION_BITS (FB)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .sample_in  (in_ch),
        .sample_out (out_ch)
    );

    // Our own copy of the resampler state and its step register.
    logic [STEP_BITS-1:0] step_q16    = STEP_UNITY;
    sample_t              held_sample = '0;
    logic                 held_valid  = 1'b0;
    logic [STEP_BITS:0]   out_pos     = '0;
    out_rec_t             due_outputs[$];

    int error_count  = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int stall_left   = 0;
    bit idle_on      = 1'b1;
    bit in_busy      = 1'b0;

    always #6 clk = ~clk;

    function automatic sample_t blend(sample_t a, sample_t b, logic [FB-1:0] frac);
        longint acc;
        acc = longint'(a) * longint'(ONE_POS) + (longint'(b) - longint'(a)) * longint'(frac);
        acc = (acc + longint'(ONE_POS >> 1)) >>> FB;
        return acc[SB-1:0];
    endfunction

    function automatic void predict_resample(sample_t cur, logic blk_end);
        logic [STEP_BITS-1:0] stp;
        out_rec_t             batch[$];
        out_rec_t             rec;
        stp = (step_q16 < STEP_FLOOR) ? STEP_FLOOR : step_q16;
        if (held_valid)
        begin
            while (out_pos < ONE_POS)
            begin
                rec = '{blend(held_sample, cur, out_pos[FB-1:0]), 1'b1, 1'b0};
                batch.insert(batch.size(), rec);
                out_pos = out_pos + stp;
            end
            out_pos = out_pos - ONE_POS;
        end
        held_sample = cur;
        held_valid  = 1'b1;
        if (blk_end)
        begin
            // Positions from the last sample up to one sample past it copy it.
            while (out_pos < ONE_POS)
            begin
                rec = '{cur, 1'b1, 1'b0};
                batch.insert(batch.size(), rec);
                out_pos = out_pos + stp;
            end
            if (batch.size() == 0)
            begin
                rec = '{'0, 1'b0, 1'b1};
                batch.insert(batch.size(), rec);
            end
            else
                batch[batch.size() - 1].last = 1'b1;
            out_pos     = '0;
            held_valid  = 1'b0;
            held_sample = '0;
        end
        foreach (batch[i])
            due_outputs.insert(due_outputs.size(), batch[i]);
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    always @(posedge clk)
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_resample(in_ch.in_sample, in_ch.block_end);

    always @(posedge clk)
    begin : check_results
        out_rec_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (due_outputs.size() == 0)
                flag_error($sformatf("unexpected result: sample %0d valid %0b last %0b",
                                     out_ch.out_sample, out_ch.sample_valid, out_ch.run_last));
            else
            begin
                want = due_outputs.pop_front();
                if (out_ch.out_sample !== want.smp || out_ch.sample_valid !== want.vld ||
                    out_ch.run_last !== want.last)
                    flag_error($sformatf("got sample %0d valid %0b last %0b, want %0d %0b %0b",
                                         out_ch.out_sample, out_ch.sample_valid,
                                         out_ch.run_last, want.smp, want.vld, want.last));
            end
        end
    end

    // Receiver stalls start at random while idle_on is set.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Leaves valid high after the accepting edge so that back-to-back
    // requests need no second assignment in the same step.
    task automatic send_item(input sample_t smp, input logic blk_end);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            if (in_busy)
                in_ch.valid <= 1'b0;
            in_busy = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_sample <= smp;
        in_ch.block_end <= blk_end;
        in_busy = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic release_input();
        if (in_busy)
            in_ch.valid <= 1'b0;
        in_busy = 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        release_input();
        while (due_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_BITS-1:0] val);
        wait_drained();
        // A request that makes no result may still be in progress.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        step_q16 = val;
    endtask

    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return SMP_MAX;
        if (sel == 1)
            return SMP_MIN;
        if (sel < 4)
            return sample_t'($signed($urandom_range(0, 511)) - 256);
        return sample_t'($urandom());
    endfunction

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(), i == len - 1);
    endtask

    task automatic run_phase(input logic [STEP_BITS-1:0] stp, input int n_items);
        int sent;
        int max_len;
        int len;
        write_step(stp);
        // Long steps give few results, so their blocks are kept short.
        max_len = (stp > 2 * STEP_UNITY) ? 4 : 12;
        sent    = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(1, max_len);
            send_block(len);
            sent += len;
        end
    endtask

    task automatic test_directed_cases();
        // A block of one sample, which is both first and last.
        send_item(SMP_MAX, 1'b1);
        send_item(SMP_MIN, 1'b0);
        send_item(SMP_MAX, 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(sample_t'(0), 1'b1);
        // Half steps land on exact ties, which round upwards.
        write_step(STEP_UNITY >> 1);
        send_item(sample_t'(0), 1'b0);
        send_item(sample_t'(1), 1'b0);
        send_item(sample_t'(0), 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(SMP_MAX, 1'b0);
        send_item(SMP_MIN, 1'b1);
        // A zero step is raised to the floor and gives the most results.
        write_step('0);
        send_item(sample_t'(5), 1'b0);
        send_item(SMP_MIN, 1'b1);
        // The longest step skips inputs and ends with a bare end marker.
        write_step(STEP_MAX);
        send_item(sample_t'(100), 1'b0);
        send_item(sample_t'(200), 1'b0);
        send_item(sample_t'(300), 1'b0);
        send_item(sample_t'(400), 1'b1);
    endtask

    task automatic test_held_sender();
        write_step(STEP_UNITY + (STEP_UNITY >> 1));
        for (int i = 0; i < 8; i++)
        begin
            send_item(pick_sample(), i == 7);
            wait_drained();
        end
    endtask

    task automatic test_random_steps();
        run_phase(STEP_FLOOR, 32);
        idle_on = 1'b0;
        run_phase(STEP_UNITY, 32);
        idle_on = 1'b1;
        run_phase(STEP_UNITY << 4, 32);
        run_phase(STEP_MAX, 32);
        run_phase(STEP_BITS'($urandom_range(0, STEP_FLOOR - 1)), 32);
        run_phase(STEP_BITS'($urandom_range(STEP_FLOOR, STEP_UNITY << 4)), 32);
        run_phase(STEP_BITS'($urandom_range(STEP_UNITY >> 2, STEP_UNITY << 1)), 32);
    endtask

    task automatic test_final_burst();
        idle_on = 1'b0;
        run_phase(STEP_BITS'($urandom_range(STEP_UNITY >> 2, STEP_UNITY << 1)), 40);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.in_sample = '0;
        in_ch.block_end = 1'b0;
        out_ch.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_held_sender();
        test_random_steps();
        test_final_burst();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

`default_nettype wire
